@@ rtl/saqt_pkg.sv @@
// Shared types and constants for the slice admission quota table.
// Used by saqt_ctrl, saqt_datapath and slice_admission_quota_table.
`default_nettype none
package saqt_pkg;

  localparam int unsigned SubW   = 50;
  localparam int unsigned SesW   = 8;
  localparam int unsigned OutCntW = 9;
  localparam int unsigned QuotaW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MaxSlices = 4;

  typedef enum logic [2:0] {
    OP_ADMIT_SUB = 3'd0,
    OP_REL_SUB   = 3'd1,
    OP_ADMIT_SES = 3'd2,
    OP_REL_SES   = 3'd3,
    OP_QUERY     = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MASK   = 3'd0,
    REG_QUOTA0 = 3'd1,
    REG_QUOTA1 = 3'd2,
    REG_QUOTA2 = 3'd3,
    REG_QUOTA3 = 3'd4
  } cfg_idx_e;

  localparam logic KindSub = 1'b0;
  localparam logic KindSes = 1'b1;

  typedef struct packed {
    logic [2:0]      operation;
    logic [1:0]      slice_index;
    logic [SubW-1:0] subscriber_id;
    logic [SesW-1:0] pdu_session;
  } req_t;

  typedef struct packed {
    logic               configured;
    logic               admitted;
    logic               table_full;
    logic [OutCntW-1:0] current_count;
    logic [QuotaW-1:0]  maximum;
    logic [OutCntW-1:0] subscriber_total;
    logic [OutCntW-1:0] session_total;
  } rsp_t;

  // One table entry, 62 bits.
  typedef struct packed {
    logic            valid;
    logic            kind;
    logic [1:0]      slice;
    logic [SubW-1:0] sub;
    logic [SesW-1:0] ses;
  } entry_t;

  typedef struct packed {
    logic clr_wr;
    logic start;
    logic scan_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic need_scan;
    logic out_free;
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

endpackage
`default_nettype wire

@@ rtl/slice_admission_quota_table.sv @@
// Top level of the per-slice admission quota table.
// Depends on saqt_pkg, saqt_ctrl and saqt_datapath.
//
// Usage:
// - Input channel in_valid_i / in_stall_o / in_req_i carries one request:
//   operation, slice, subscriber and session. It is taken at a clock edge
//   with valid high and stall low.
// - Output channel out_valid_o / out_stall_i / out_rsp_o returns exactly
//   one response per request, in order.
// - Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 slice mask, 1..4 slice quotas). Write only while idle.
// Timing:
// - Admits and releases on a known slice scan the entry memory one entry
//   per cycle through its single read port. Queries, unknown slices and unused
//   opcodes skip the scan. One request is in work at a time; the next one can be
//   taken in the cycle after the response is written.
// - A finished response sits in the output register; the next request is
//   accepted and scanned while it waits. A stalled receiver holds the
//   response and blocks only the commit of the following request.
// Reset: counters, config and valid state clear; then a clearing pass
//   invalidates every entry, with in_stall_o high.
`default_nettype none
module slice_admission_quota_table #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned NUM_SLICES  = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire saqt_pkg::req_t                in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output saqt_pkg::rsp_t                     out_rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [saqt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [saqt_pkg::CfgDataW-1:0] cfg_wdata_i
);

  saqt_pkg::cmd_t    cmd;
  saqt_pkg::status_t sts;

  saqt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  saqt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_SLICES  (NUM_SLICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

@@ rtl/saqt_ctrl.sv @@
// Sequencer for the admission table: clear sweep, scan, decide.
// Depends on saqt_pkg.
`default_nettype none
module saqt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire saqt_pkg::status_t sts_i,
  output saqt_pkg::cmd_t        cmd_o
);

  saqt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= saqt_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      saqt_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.ptr_last) state_d = saqt_pkg::ST_IDLE;
      end
      saqt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = saqt_pkg::ST_SCAN;
        end
      end
      saqt_pkg::ST_SCAN: begin
        if (!sts_i.need_scan) begin
          state_d = saqt_pkg::ST_DECIDE;
        end else begin
          cmd_o.scan_rd = 1'b1;
          if (sts_i.ptr_last) state_d = saqt_pkg::ST_DRAIN;
        end
      end
      saqt_pkg::ST_DRAIN: state_d = saqt_pkg::ST_DECIDE;
      saqt_pkg::ST_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = saqt_pkg::ST_IDLE;
        end
      end
      default: state_d = saqt_pkg::ST_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/saqt_datapath.sv @@
// Entry memory, scan compare, slice counters, config registers, output register.
// Depends on saqt_pkg.
`default_nettype none
module saqt_datapath #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned NUM_SLICES  = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire saqt_pkg::req_t                   req_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [saqt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [saqt_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire saqt_pkg::cmd_t                   cmd_i,
  output saqt_pkg::status_t                     sts_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output saqt_pkg::rsp_t                        out_rsp_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SlW  = (NUM_SLICES > 1) ? $clog2(NUM_SLICES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  // config
  logic [saqt_pkg::MaxSlices-1:0] mask_q;
  logic [saqt_pkg::CfgDataW-1:0]  quota_q [NUM_SLICES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == saqt_pkg::REG_MASK) begin
      mask_q <= cfg_wdata_i[saqt_pkg::MaxSlices-1:0];
    end
  end

  for (genvar s = 0; s < NUM_SLICES; s++) begin : g_quota
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        quota_q[s] <= '0;
      end else if (cfg_we_i &&
                   cfg_idx_i == saqt_pkg::CfgIdxW'(int'(saqt_pkg::REG_QUOTA0) + s)) begin
        quota_q[s] <= cfg_wdata_i;
      end
    end
  end

  // captured request
  saqt_pkg::req_t req_q, req_d;
  always_comb begin
    req_d = req_i;
    // session field means nothing to subscriber operations
    if (req_i.operation == saqt_pkg::OP_ADMIT_SUB ||
        req_i.operation == saqt_pkg::OP_REL_SUB) begin
      req_d.pdu_session = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) req_q <= req_d;
  end

  logic op_ok, slice_ok, known, is_query, is_release, is_admit, kind;
  logic [SlW-1:0] sl;
  assign op_ok      = req_q.operation <= saqt_pkg::OP_QUERY;
  assign slice_ok   = 32'(req_q.slice_index) < NUM_SLICES;
  assign known      = op_ok && slice_ok && mask_q[req_q.slice_index];
  assign is_query   = req_q.operation == saqt_pkg::OP_QUERY;
  assign is_release = req_q.operation == saqt_pkg::OP_REL_SUB ||
                      req_q.operation == saqt_pkg::OP_REL_SES;
  assign is_admit   = req_q.operation == saqt_pkg::OP_ADMIT_SUB ||
                      req_q.operation == saqt_pkg::OP_ADMIT_SES;
  assign kind       = (req_q.operation == saqt_pkg::OP_ADMIT_SES ||
                       req_q.operation == saqt_pkg::OP_REL_SES) ? saqt_pkg::KindSes
                                                                 : saqt_pkg::KindSub;
  assign sl         = SlW'(req_q.slice_index);

  // pointer shared by clear sweep and scan
  logic [IdxW-1:0] ptr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.start) begin
      ptr_q <= '0;
    end else if (cmd_i.clr_wr || cmd_i.scan_rd) begin
      ptr_q <= (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
    end
  end

  // entry memory
  saqt_pkg::entry_t mem [TABLE_DEPTH];
  saqt_pkg::entry_t rdata_q, wdata;
  logic             mem_we;
  logic [IdxW-1:0]  waddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (cmd_i.scan_rd) rdata_q <= mem[ptr_q];
  end

  logic            cmp_v_q;
  logic [IdxW-1:0] cmp_addr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_v_q    <= 1'b0;
      cmp_addr_q <= '0;
    end else begin
      cmp_v_q    <= cmd_i.scan_rd;
      cmp_addr_q <= ptr_q;
    end
  end

  logic hit;
  assign hit = rdata_q.valid && rdata_q.kind == kind &&
               rdata_q.slice == req_q.slice_index &&
               rdata_q.sub == req_q.subscriber_id &&
               (kind == saqt_pkg::KindSub || rdata_q.ses == req_q.pdu_session);

  logic            match_f_q, free_f_q;
  logic [IdxW-1:0] match_idx_q, free_idx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_f_q   <= 1'b0;
      free_f_q    <= 1'b0;
      match_idx_q <= '0;
      free_idx_q  <= '0;
    end else if (cmd_i.start) begin
      match_f_q <= 1'b0;
      free_f_q  <= 1'b0;
    end else if (cmp_v_q) begin
      if (!match_f_q && hit) begin
        match_f_q   <= 1'b1;
        match_idx_q <= cmp_addr_q;
      end
      if (!free_f_q && !rdata_q.valid) begin
        free_f_q   <= 1'b1;
        free_idx_q <= cmp_addr_q;
      end
    end
  end

  // slice counters
  logic [CntW-1:0] sub_cnt_q [NUM_SLICES];
  logic [CntW-1:0] ses_cnt_q [NUM_SLICES];
  logic [CntW-1:0] cnt, cnt_new;
  logic [saqt_pkg::QuotaW-1:0] quota;
  logic do_insert, do_release;
  saqt_pkg::rsp_t res;

  assign cnt   = (kind == saqt_pkg::KindSes) ? ses_cnt_q[sl] : sub_cnt_q[sl];
  assign quota = (kind == saqt_pkg::KindSes) ? quota_q[sl][31:16] : quota_q[sl][15:0];

  always_comb begin
    res        = '0;
    cnt_new    = cnt;
    do_insert  = 1'b0;
    do_release = 1'b0;
    if (known) begin
      res.configured = 1'b1;
      if (is_query) begin
        res.subscriber_total = saqt_pkg::OutCntW'(sub_cnt_q[sl]);
        res.session_total    = saqt_pkg::OutCntW'(ses_cnt_q[sl]);
      end else begin
        if (is_release) begin
          if (match_f_q) begin
            do_release = 1'b1;
            if (cnt != '0) cnt_new = cnt - 1'b1;
          end
        end else if (is_admit) begin
          res.maximum = quota;
          if (match_f_q) begin
            res.admitted = 1'b1;
          end else if (17'(cnt) < 17'(quota)) begin
            if (!free_f_q) begin
              res.table_full = 1'b1;
            end else begin
              do_insert    = 1'b1;
              cnt_new      = cnt + 1'b1;
              res.admitted = 1'b1;
            end
          end
        end
        res.current_count = saqt_pkg::OutCntW'(cnt_new);
      end
    end
  end

  for (genvar s = 0; s < NUM_SLICES; s++) begin : g_cnt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sub_cnt_q[s] <= '0;
        ses_cnt_q[s] <= '0;
      end else if (cmd_i.commit && known && !is_query && sl == SlW'(s)) begin
        if (kind == saqt_pkg::KindSes) ses_cnt_q[s] <= cnt_new;
        else sub_cnt_q[s] <= cnt_new;
      end
    end
  end

  // memory write: clear sweep, insert or release
  always_comb begin
    wdata  = '0;
    waddr  = ptr_q;
    mem_we = cmd_i.clr_wr;
    if (cmd_i.commit && do_insert) begin
      mem_we      = 1'b1;
      waddr       = free_idx_q;
      wdata.valid = 1'b1;
      wdata.kind  = kind;
      wdata.slice = req_q.slice_index;
      wdata.sub   = req_q.subscriber_id;
      wdata.ses   = req_q.pdu_session;
    end else if (cmd_i.commit && do_release) begin
      mem_we = 1'b1;
      waddr  = match_idx_q;
    end
  end

  // output register
  logic out_v_q;
  saqt_pkg::rsp_t rsp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) rsp_q <= res;
  end

  assign out_valid_o     = out_v_q;
  assign out_rsp_o       = rsp_q;
  assign sts_o.ptr_last  = ptr_q == LastIdx;
  assign sts_o.need_scan = known && !is_query;
  assign sts_o.out_free  = !out_v_q || !out_stall_i;

endmodule
`default_nettype wire
